>>> design/ste_pkg.sv
// Shared types, codes and constants for the scanline track shape estimator.
package ste_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_BLACK_LEVEL         = 3'd0,
    REG_RED_LEVEL           = 3'd1,
    REG_WHITE_LEVEL         = 3'd2,
    REG_STRAIGHT_TOLERANCE  = 3'd3,
    REG_ERROR_LIMIT_PERCENT = 3'd4
  } cfg_reg_t;

  // Frame verdict codes.
  typedef enum logic [2:0] {
    VERDICT_STRAIGHT = 3'd0,
    VERDICT_LEFT     = 3'd1,
    VERDICT_RIGHT    = 3'd2,
    VERDICT_NOT_EST  = 3'd3,
    VERDICT_AT_TOL   = 3'd4
  } verdict_t;

  // Configuration register set.
  typedef struct packed {
    logic [7:0] black_level;
    logic [7:0] red_level;
    logic [7:0] white_level;
    logic [9:0] straight_tolerance;
    logic [6:0] error_limit_percent;
  } cfg_t;

  // Flags carried with each finished line.
  typedef struct packed {
    logic pattern_found;
    logic end_of_frame;
  } line_flags_t;

  localparam int PIXEL_W    = 8;
  localparam int CFG_DATA_W = 10;
  localparam int CENTER_W   = 12;
  localparam int VERDICT_W  = 3;
  localparam int COUNT_W    = 11;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 11'd2047;
  localparam int PROD_W     = 19;
  localparam logic [6:0] PCT_SCALE = 7'd100;
  localparam logic [2:0] MATCH_LAST = 3'd4;

  // Expected run value at each position of the five-run pattern.
  function automatic logic [PIXEL_W-1:0] pattern_level(input cfg_t cfg,
                                                       input logic [2:0] pos);
    logic [PIXEL_W-1:0] lvl;
    unique case (pos)
      3'd1, 3'd3: lvl = cfg.white_level;
      3'd2:       lvl = cfg.red_level;
      default:    lvl = cfg.black_level;
    endcase
    return lvl;
  endfunction

endpackage

>>> design/ste_queue.sv
// Small first-in first-out queue in flip-flops with push/full and pop/empty sides.
module ste_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] store [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_FULL);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = store[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= wdata;
    end
  end

endmodule

>>> design/ste_front.sv
// Per-pixel front end: run collapsing, pattern matching and red segment search.
module ste_front #(
  parameter int LINE_PIXELS = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  input  ste_pkg::cfg_t                      cfg,
  input  logic                               accept,
  input  logic [ste_pkg::PIXEL_W-1:0]        pixel,
  input  logic                               end_of_line,
  input  logic                               end_of_frame,
  output logic                               rec_push,
  output ste_pkg::line_flags_t               rec_flags,
  output logic signed [$clog2(LINE_PIXELS)+1:0] rec_center
);

  localparam int IDXW = $clog2(LINE_PIXELS);
  localparam int CW   = IDXW + 2;
  localparam logic [IDXW-1:0] IDX_MAX = IDXW'(LINE_PIXELS - 1);

  logic [ste_pkg::PIXEL_W-1:0] prev_pixel;
  logic                        line_started;
  logic [2:0]                  match_pos, match_pos_next;
  logic                        match_hit, match_hit_next;
  logic [IDXW-1:0]             pixel_index, pixel_index_next;
  logic                        start_valid, start_valid_next;
  logic [IDXW-1:0]             red_start, red_start_next;
  logic                        end_valid, end_valid_next;
  logic [IDXW-1:0]             red_end, red_end_next;
  logic                        feed;
  logic                        line_end;
  logic [CW-1:0]               center_sum;

  assign line_end = end_of_line || end_of_frame;

  // Next state for one accepted pixel.
  always_comb begin
    match_pos_next   = match_pos;
    match_hit_next   = match_hit;
    start_valid_next = start_valid;
    red_start_next   = red_start;
    end_valid_next   = end_valid;
    red_end_next     = red_end;
    pixel_index_next = '0;
    feed             = 1'b1;

    if (line_started) begin
      pixel_index_next = (pixel_index == IDX_MAX) ? IDX_MAX : pixel_index + 1'b1;
      // The previous pixel is tested with this pixel as its successor.
      if (!end_valid) begin
        priority if (prev_pixel == cfg.white_level && pixel == cfg.red_level) begin
          start_valid_next = 1'b1;
          red_start_next   = pixel_index_next;
        end else if (prev_pixel == cfg.red_level && pixel == cfg.white_level &&
                     start_valid) begin
          end_valid_next = 1'b1;
          red_end_next   = pixel_index;
        end else if (prev_pixel == cfg.black_level && start_valid) begin
          start_valid_next = 1'b0;
        end
      end
      feed = (pixel != prev_pixel);
    end

    // A new run value advances or restarts the pattern match.
    if (feed && !match_hit) begin
      if (pixel == ste_pkg::pattern_level(cfg, match_pos)) begin
        if (match_pos == ste_pkg::MATCH_LAST) begin
          match_hit_next = 1'b1;
          match_pos_next = '0;
        end else begin
          match_pos_next = match_pos + 1'b1;
        end
      end else begin
        match_pos_next = '0;
      end
    end

    // The last pixel has no successor; only a black pixel clearing a start applies.
    if (line_end && !end_valid_next && pixel == cfg.black_level && start_valid_next) begin
      start_valid_next = 1'b0;
    end
  end

  assign center_sum = {2'b00, red_start_next} + {2'b00, red_end_next};

  assign rec_push                = accept && line_end;
  assign rec_flags.pattern_found = match_hit_next;
  assign rec_flags.end_of_frame  = end_of_frame;
  assign rec_center = (start_valid_next && end_valid_next) ? signed'(center_sum)
                                                           : signed'(~CW'(1));

  // Line state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_started <= 1'b0;
      match_pos    <= '0;
      match_hit    <= 1'b0;
      pixel_index  <= '0;
      start_valid  <= 1'b0;
      end_valid    <= 1'b0;
    end else if (accept) begin
      if (line_end) begin
        line_started <= 1'b0;
        match_pos    <= '0;
        match_hit    <= 1'b0;
        pixel_index  <= '0;
        start_valid  <= 1'b0;
        end_valid    <= 1'b0;
      end else begin
        line_started <= 1'b1;
        match_pos    <= match_pos_next;
        match_hit    <= match_hit_next;
        pixel_index  <= pixel_index_next;
        start_valid  <= start_valid_next;
        end_valid    <= end_valid_next;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      prev_pixel <= pixel;
      red_start  <= red_start_next;
      red_end    <= red_end_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_idle_line_clear: assert property (@(posedge clk) disable iff (rst)
    !line_started |-> (match_pos == '0 && !match_hit && !start_valid && !end_valid))
    else $error("line state not clear between lines");
  a_end_needs_start: assert property (@(posedge clk) disable iff (rst)
    end_valid |-> start_valid)
    else $error("segment end found without a start");
  a_match_pos_range: assert property (@(posedge clk) disable iff (rst)
    match_hit |-> (match_pos == '0))
    else $error("match position not cleared after a hit");
`endif

endmodule

>>> design/ste_back.sv
// Per-line back end: frame statistics and the frame shape verdict.
module ste_back #(
  parameter int CW = 12
) (
  input  logic                               clk,
  input  logic                               rst,
  input  ste_pkg::cfg_t                      cfg,
  input  logic                               q_empty,
  input  ste_pkg::line_flags_t               q_flags,
  input  logic signed [CW-1:0]               q_center,
  output logic                               q_pop,
  input  logic                               out_full,
  output logic                               out_push,
  output logic                               out_pattern_found,
  output logic signed [ste_pkg::CENTER_W-1:0] out_center_x2,
  output logic                               out_frame_done,
  output ste_pkg::verdict_t                  out_verdict
);

  localparam int DW = (CW + 1 > 12) ? CW + 1 : 12;

  logic [ste_pkg::COUNT_W-1:0] hit_count, hit_count_next;
  logic [ste_pkg::COUNT_W-1:0] miss_count, miss_count_next;
  logic signed [CW-1:0]        first_center, first_center_next;
  logic signed [CW-1:0]        last_center, last_center_next;
  logic [ste_pkg::COUNT_W:0]   total;
  logic [ste_pkg::PROD_W-1:0]  miss_prod;
  logic [ste_pkg::PROD_W-1:0]  limit_prod;
  logic signed [DW-1:0]        delta;

  logic                        s1_valid;
  ste_pkg::line_flags_t        s1_flags;
  logic signed [CW-1:0]        s1_center;
  logic [ste_pkg::PROD_W-1:0]  s1_miss_prod;
  logic [ste_pkg::PROD_W-1:0]  s1_limit_prod;
  logic signed [DW-1:0]        s1_delta;
  logic                        s1_ready;
  logic signed [DW-1:0]        tol2;
  logic signed [DW-1:0]        tol2_neg;

  assign s1_ready = !s1_valid || !out_full;
  assign q_pop    = !q_empty && s1_ready;
  assign out_push = s1_valid && !out_full;

  // Statistics updated by the line being taken.
  always_comb begin
    hit_count_next    = hit_count;
    miss_count_next   = miss_count;
    first_center_next = first_center;
    last_center_next  = last_center;
    if (q_flags.pattern_found) begin
      if (hit_count != ste_pkg::COUNT_MAX) begin
        hit_count_next = hit_count + 1'b1;
        if (hit_count == '0) begin
          first_center_next = q_center;
        end
      end
      last_center_next = q_center;
    end else if (miss_count != ste_pkg::COUNT_MAX) begin
      miss_count_next = miss_count + 1'b1;
    end
  end

  // Miss rate products and midpoint shift, registered before the compare.
  assign total      = {1'b0, hit_count_next} + {1'b0, miss_count_next};
  assign miss_prod  = ste_pkg::PROD_W'(miss_count_next) * ste_pkg::PROD_W'(ste_pkg::PCT_SCALE);
  assign limit_prod = ste_pkg::PROD_W'(cfg.error_limit_percent) * ste_pkg::PROD_W'(total);
  assign delta      = DW'(first_center_next) - DW'(last_center_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_count    <= '0;
      miss_count   <= '0;
      first_center <= '0;
      last_center  <= '0;
      s1_valid     <= 1'b0;
    end else begin
      if (q_pop) begin
        if (q_flags.end_of_frame) begin
          hit_count    <= '0;
          miss_count   <= '0;
          first_center <= '0;
          last_center  <= '0;
        end else begin
          hit_count    <= hit_count_next;
          miss_count   <= miss_count_next;
          first_center <= first_center_next;
          last_center  <= last_center_next;
        end
      end
      if (s1_ready) begin
        s1_valid <= q_pop;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_flags      <= q_flags;
      s1_center     <= q_center;
      s1_miss_prod  <= miss_prod;
      s1_limit_prod <= limit_prod;
      s1_delta      <= delta;
    end
  end

  // Verdict from the registered products and shift.
  assign tol2     = DW'({cfg.straight_tolerance, 1'b0});
  assign tol2_neg = -tol2;

  always_comb begin
    if (!s1_flags.end_of_frame) begin
      out_verdict = ste_pkg::VERDICT_STRAIGHT;
    end else begin
      priority if (s1_miss_prod > s1_limit_prod) begin
        out_verdict = ste_pkg::VERDICT_NOT_EST;
      end else if (s1_delta < tol2 && s1_delta > tol2_neg) begin
        out_verdict = ste_pkg::VERDICT_STRAIGHT;
      end else if (s1_delta < tol2_neg) begin
        out_verdict = ste_pkg::VERDICT_LEFT;
      end else if (s1_delta > tol2) begin
        out_verdict = ste_pkg::VERDICT_RIGHT;
      end else begin
        out_verdict = ste_pkg::VERDICT_AT_TOL;
      end
    end
  end

  assign out_pattern_found = s1_flags.pattern_found;
  assign out_frame_done    = s1_flags.end_of_frame;
  assign out_center_x2     = ste_pkg::CENTER_W'(s1_center);

`ifndef NO_ASSERTIONS
  a_frame_clears: assert property (@(posedge clk) disable iff (rst)
    (q_pop && q_flags.end_of_frame) |=> (hit_count == '0 && miss_count == '0))
    else $error("frame statistics not cleared after frame end");
  a_no_hit_no_center: assert property (@(posedge clk) disable iff (rst)
    (hit_count == '0) |-> (first_center == '0 && last_center == '0))
    else $error("midpoints kept without a hit");
  a_no_push_on_full: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_full) |=> s1_valid)
    else $error("stalled line result lost");
`endif

endmodule

>>> design/scanline_track_shape_estimator_unit.sv
// Top level of the scanline track shape estimator: configuration, front, queues, back.
// The unit takes one pixel per clock cycle when full is low; the front end classifies
// each pixel and hands one record per scanline to a four-entry queue. The back end
// registers a record's statistics and products, then makes the verdict compare from
// those registers and places the result in a two-entry result queue. A finished line
// passes through the line queue, the back end stage register and the result queue on
// its way to the result ports. The pixel side stalls while the line queue is full,
// which happens only after the back end stage and the result queue have backed up.
// Configuration writes are always ready and must be made while the unit is idle.
module scanline_track_shape_estimator_unit #(
  parameter int LINE_PIXELS = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic [ste_pkg::PIXEL_W-1:0]         pixel,
  input  logic                                end_of_line,
  input  logic                                end_of_frame,
  output logic                                empty,
  input  logic                                pop,
  output logic                                pattern_found,
  output logic signed [ste_pkg::CENTER_W-1:0] center_x2,
  output logic                                frame_done,
  output logic [ste_pkg::VERDICT_W-1:0]       verdict,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [2:0]                          cfg_index,
  input  logic [ste_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int CW     = $clog2(LINE_PIXELS) + 2;
  localparam int LINE_W = CW + 2;
  localparam int OUT_W  = ste_pkg::CENTER_W + ste_pkg::VERDICT_W + 2;

  ste_pkg::cfg_t              cfg;
  logic                       accept;
  logic                       rec_push;
  ste_pkg::line_flags_t       rec_flags;
  logic signed [CW-1:0]       rec_center;
  logic                       q_empty;
  logic                       q_pop;
  logic [LINE_W-1:0]          q_rdata;
  ste_pkg::line_flags_t       q_flags;
  logic signed [CW-1:0]       q_center;
  logic                       out_full;
  logic                       out_push;
  logic                       b_found;
  logic signed [ste_pkg::CENTER_W-1:0] b_center;
  logic                       b_frame_done;
  ste_pkg::verdict_t          b_verdict;
  logic [OUT_W-1:0]           out_rdata;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.black_level         <= 8'd0;
      cfg.red_level           <= 8'd128;
      cfg.white_level         <= 8'd255;
      cfg.straight_tolerance  <= 10'd30;
      cfg.error_limit_percent <= 7'd30;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ste_pkg::REG_BLACK_LEVEL:         cfg.black_level <= cfg_data[7:0];
        ste_pkg::REG_RED_LEVEL:           cfg.red_level <= cfg_data[7:0];
        ste_pkg::REG_WHITE_LEVEL:         cfg.white_level <= cfg_data[7:0];
        ste_pkg::REG_STRAIGHT_TOLERANCE:  cfg.straight_tolerance <= cfg_data[9:0];
        ste_pkg::REG_ERROR_LIMIT_PERCENT: cfg.error_limit_percent <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Pixel side: the line queue decides whether a pixel can be taken.
  assign accept = push && !full;

  ste_front #(
    .LINE_PIXELS (LINE_PIXELS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .accept       (accept),
    .pixel        (pixel),
    .end_of_line  (end_of_line),
    .end_of_frame (end_of_frame),
    .rec_push     (rec_push),
    .rec_flags    (rec_flags),
    .rec_center   (rec_center)
  );

  ste_queue #(
    .WIDTH (LINE_W),
    .DEPTH (4)
  ) u_line_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (rec_push),
    .wdata ({rec_flags, rec_center}),
    .full  (full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign q_flags  = q_rdata[LINE_W-1 -: 2];
  assign q_center = signed'(q_rdata[CW-1:0]);

  ste_back #(
    .CW (CW)
  ) u_back (
    .clk               (clk),
    .rst               (rst),
    .cfg               (cfg),
    .q_empty           (q_empty),
    .q_flags           (q_flags),
    .q_center          (q_center),
    .q_pop             (q_pop),
    .out_full          (out_full),
    .out_push          (out_push),
    .out_pattern_found (b_found),
    .out_center_x2     (b_center),
    .out_frame_done    (b_frame_done),
    .out_verdict       (b_verdict)
  );

  // Result queue.
  ste_queue #(
    .WIDTH (OUT_W),
    .DEPTH (2)
  ) u_out_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .wdata ({b_found, b_frame_done, b_verdict, b_center}),
    .full  (out_full),
    .pop   (pop),
    .rdata (out_rdata),
    .empty (empty)
  );

  assign pattern_found = out_rdata[OUT_W-1];
  assign frame_done    = out_rdata[OUT_W-2];
  assign verdict       = out_rdata[ste_pkg::CENTER_W +: ste_pkg::VERDICT_W];
  assign center_x2     = signed'(out_rdata[ste_pkg::CENTER_W-1:0]);

endmodule
